@@ sv/vde_pkg.sv @@
package vde_pkg;

    localparam int ELEM_W     = 16;
    localparam int DATA_W     = 48;
    localparam int NORM_W     = 43;
    localparam int MODE_W     = 2;
    localparam int MUL_W      = 33;
    localparam int PROD_W     = 64;
    localparam int NORM_SHIFT = 20;
    localparam int SQ_N_W     = 64;
    localparam int SQ_ROOT_W  = 32;
    localparam int SQ_REM_W   = 35;
    localparam int SQRT_STEPS = 32;
    localparam int DIV_STEPS  = 16;
    localparam int CNT_W      = 5;
    localparam int QC_W       = 17;

    localparam logic [MODE_W-1:0] MODE_DOT  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_EUCL = 2'd1;
    localparam logic [MODE_W-1:0] MODE_MANH = 2'd2;
    localparam logic [MODE_W-1:0] MODE_COS  = 2'd3;

    localparam logic [DATA_W-1:0] ONE_Q15 = DATA_W'(32768);
    localparam logic [QC_W-1:0]   ONE_QC  = QC_W'(32768);

    typedef enum logic [11:0] {
        S_IDLE = 12'b0000_0000_0001,
        S_TERM = 12'b0000_0000_0010,
        S_NRMA = 12'b0000_0000_0100,
        S_NRMB = 12'b0000_0000_1000,
        S_ACCB = 12'b0000_0001_0000,
        S_SQRT = 12'b0000_0010_0000,
        S_MULR = 12'b0000_0100_0000,
        S_DEN  = 12'b0000_1000_0000,
        S_DCHK = 12'b0001_0000_0000,
        S_DIV  = 12'b0010_0000_0000,
        S_COS  = 12'b0100_0000_0000,
        S_EMIT = 12'b1000_0000_0000
    } t_state;

endpackage

@@ sv/vector_distance_engine_core.sv @@
// Each element request is accepted, then takes one shared multiplier pass per product.
// After the final accumulate of the last element, dot and Manhattan results go straight to
// the output stage; Euclidean mode first runs a 32-step square root, and cosine mode runs
// two roots, one multiply and a 16-step divide on the shared subtractor (the divide is
// skipped when the similarity saturates, and all of this when a norm is zero).
// A finished result waits in the output register while the next vector streams in.
// Reset is synchronous and active low; it clears the mode, the sums and the output valid.
module vector_distance_engine_core (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_wr_en,
    input  logic [vde_pkg::MODE_W-1:0]     i_cfg_wr_data,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    input  logic [2*vde_pkg::ELEM_W-1:0]   s_axis_tdata,   // elem_a, elem_b
    input  logic                           s_axis_tlast,
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    output logic [vde_pkg::DATA_W-1:0]     m_axis_tdata,   // distance_value
    output logic                           m_axis_tuser    // degenerate
);
    import vde_pkg::*;

    t_state                    r_state, n_state;
    logic [MODE_W-1:0]         r_mode, n_mode;
    logic signed [ELEM_W-1:0]  r_a, n_a, r_b, n_b;
    logic                      r_last, n_last;
    logic [PROD_W-1:0]         r_prod, n_prod;
    logic [DATA_W-1:0]         r_primary, n_primary;
    logic [NORM_W-1:0]         r_norm_a, n_norm_a, r_norm_b, n_norm_b;
    logic [SQ_N_W-1:0]         r_sq_n, n_sq_n;
    logic [SQ_REM_W-1:0]       r_sq_rem, n_sq_rem;
    logic [SQ_ROOT_W-1:0]      r_sq_root, n_sq_root, r_ra, n_ra;
    logic                      r_sq_second, n_sq_second;
    logic [CNT_W-1:0]          r_cnt, n_cnt;
    logic [NORM_W-1:0]         r_den, n_den;
    logic [DATA_W-1:0]         r_div_rem, n_div_rem;
    logic [DIV_STEPS-1:0]      r_quot, n_quot;
    logic                      r_neg, n_neg, r_sat, n_sat;
    logic [DATA_W-1:0]         r_res_val, n_res_val;
    logic                      r_res_deg, n_res_deg;
    logic                      r_out_valid, n_out_valid;
    logic [DATA_W-1:0]         r_out_data, n_out_data;
    logic                      r_out_deg, n_out_deg;

    logic signed [ELEM_W:0]    w_diff;
    logic [ELEM_W:0]           w_absd;
    logic signed [MUL_W-1:0]   w_mul_x, w_mul_y;
    logic signed [2*MUL_W-1:0] w_mul_p;
    logic [SQ_REM_W-1:0]       w_sq_rem_sh, w_sq_trial;
    logic [SQ_ROOT_W-1:0]      w_sq_root_nx;
    logic [DATA_W-1:0]         w_cs_x, w_cs_y, w_cs_diff;
    logic                      w_cs_ge;
    logic [QC_W-1:0]           w_qc;

    assign w_diff = {r_a[ELEM_W-1], r_a} - {r_b[ELEM_W-1], r_b};
    assign w_absd = w_diff[ELEM_W] ? (~w_diff + 1'b1) : w_diff;

    // Shared multiplier: element products and the product of the two norm roots.
    always_comb begin
        unique case (r_state)
            S_TERM: begin
                if (r_mode == MODE_EUCL) begin
                    w_mul_x = MUL_W'(w_diff);
                    w_mul_y = MUL_W'(w_diff);
                end else begin
                    w_mul_x = MUL_W'(r_a);
                    w_mul_y = MUL_W'(r_b);
                end
            end
            S_NRMA: begin
                w_mul_x = MUL_W'(r_a);
                w_mul_y = MUL_W'(r_a);
            end
            S_NRMB: begin
                w_mul_x = MUL_W'(r_b);
                w_mul_y = MUL_W'(r_b);
            end
            S_MULR: begin
                w_mul_x = {1'b0, r_ra};
                w_mul_y = {1'b0, r_sq_root};
            end
            default: begin
                w_mul_x = '0;
                w_mul_y = '0;
            end
        endcase
    end

    assign w_mul_p = w_mul_x * w_mul_y;

    assign w_sq_rem_sh = {r_sq_rem[SQ_REM_W-3:0], r_sq_n[SQ_N_W-1 -: 2]};
    assign w_sq_trial  = {1'b0, r_sq_root, 2'b01};

    // Shared compare and subtract: square root steps, saturation check and divide steps.
    always_comb begin
        unique case (r_state)
            S_SQRT: begin
                w_cs_x = DATA_W'(w_sq_rem_sh);
                w_cs_y = DATA_W'(w_sq_trial);
            end
            S_DCHK: begin
                w_cs_x = r_div_rem;
                w_cs_y = DATA_W'({r_den, 1'b0});
            end
            S_DIV: begin
                w_cs_x = (r_cnt == '0) ? r_div_rem : {r_div_rem[DATA_W-2:0], 1'b0};
                w_cs_y = DATA_W'(r_den);
            end
            default: begin
                w_cs_x = '0;
                w_cs_y = '0;
            end
        endcase
    end

    assign w_cs_ge   = (w_cs_x >= w_cs_y);
    assign w_cs_diff = w_cs_x - w_cs_y;

    assign w_sq_root_nx = {r_sq_root[SQ_ROOT_W-2:0], w_cs_ge};

    assign w_qc = r_sat ? ONE_QC :
                  ((QC_W'(r_quot) > ONE_QC) ? ONE_QC : QC_W'(r_quot));

    always_comb begin
        n_state     = r_state;
        n_mode      = r_mode;
        n_a         = r_a;
        n_b         = r_b;
        n_last      = r_last;
        n_prod      = r_prod;
        n_primary   = r_primary;
        n_norm_a    = r_norm_a;
        n_norm_b    = r_norm_b;
        n_sq_n      = r_sq_n;
        n_sq_rem    = r_sq_rem;
        n_sq_root   = r_sq_root;
        n_sq_second = r_sq_second;
        n_ra        = r_ra;
        n_cnt       = r_cnt;
        n_den       = r_den;
        n_div_rem   = r_div_rem;
        n_quot      = r_quot;
        n_neg       = r_neg;
        n_sat       = r_sat;
        n_res_val   = r_res_val;
        n_res_deg   = r_res_deg;
        n_out_valid = r_out_valid;
        n_out_data  = r_out_data;
        n_out_deg   = r_out_deg;

        if (i_cfg_wr_en) begin
            n_mode = i_cfg_wr_data;
        end
        if (r_out_valid && m_axis_tready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (s_axis_tvalid) begin
                    n_a     = s_axis_tdata[ELEM_W-1:0];
                    n_b     = s_axis_tdata[2*ELEM_W-1:ELEM_W];
                    n_last  = s_axis_tlast;
                    n_state = S_TERM;
                end
            end
            S_TERM: begin
                if (r_mode == MODE_MANH) begin
                    n_prod = PROD_W'(w_absd);
                end else begin
                    n_prod = w_mul_p[PROD_W-1:0];
                end
                n_state = S_NRMA;
            end
            S_NRMA: begin
                n_primary = r_primary + r_prod[DATA_W-1:0];
                n_prod    = w_mul_p[PROD_W-1:0];
                n_state   = S_NRMB;
            end
            S_NRMB: begin
                n_norm_a = r_norm_a + r_prod[NORM_W-1:0];
                n_prod   = w_mul_p[PROD_W-1:0];
                n_state  = S_ACCB;
            end
            S_ACCB: begin
                n_norm_b = r_norm_b + r_prod[NORM_W-1:0];
                if (!r_last) begin
                    n_state = S_IDLE;
                end else begin
                    n_sq_rem    = '0;
                    n_sq_root   = '0;
                    n_cnt       = '0;
                    n_sq_second = 1'b0;
                    n_res_deg   = 1'b0;
                    case (r_mode)
                        MODE_EUCL: begin
                            n_sq_n  = SQ_N_W'(r_primary);
                            n_state = S_SQRT;
                        end
                        MODE_COS: begin
                            if ((r_norm_a == '0) || (n_norm_b == '0)) begin
                                n_res_val = ONE_Q15;
                                n_res_deg = 1'b1;
                                n_state   = S_EMIT;
                            end else begin
                                n_sq_n  = SQ_N_W'({r_norm_a, {NORM_SHIFT{1'b0}}});
                                n_state = S_SQRT;
                            end
                        end
                        default: begin
                            n_res_val = r_primary;
                            n_state   = S_EMIT;
                        end
                    endcase
                end
            end
            S_SQRT: begin
                n_sq_n    = {r_sq_n[SQ_N_W-3:0], 2'b00};
                n_sq_rem  = w_cs_ge ? w_cs_diff[SQ_REM_W-1:0] : w_sq_rem_sh;
                n_sq_root = w_sq_root_nx;
                n_cnt     = r_cnt + 1'b1;
                if (r_cnt == CNT_W'(SQRT_STEPS-1)) begin
                    if (r_mode == MODE_EUCL) begin
                        n_res_val = DATA_W'(w_sq_root_nx);
                        n_state   = S_EMIT;
                    end else if (!r_sq_second) begin
                        n_ra        = w_sq_root_nx;
                        n_sq_second = 1'b1;
                        n_sq_n      = SQ_N_W'({r_norm_b, {NORM_SHIFT{1'b0}}});
                        n_sq_rem    = '0;
                        n_sq_root   = '0;
                        n_cnt       = '0;
                    end else begin
                        n_state = S_MULR;
                    end
                end
            end
            S_MULR: begin
                n_prod  = w_mul_p[PROD_W-1:0];
                n_state = S_DEN;
            end
            S_DEN: begin
                if (r_prod[NORM_SHIFT +: NORM_W] == '0) begin
                    n_den = NORM_W'(1);
                end else begin
                    n_den = r_prod[NORM_SHIFT +: NORM_W];
                end
                n_neg     = r_primary[DATA_W-1];
                n_div_rem = r_primary[DATA_W-1] ? (~r_primary + 1'b1) : r_primary;
                n_state   = S_DCHK;
            end
            S_DCHK: begin
                n_sat   = w_cs_ge;
                n_cnt   = '0;
                n_quot  = '0;
                n_state = w_cs_ge ? S_COS : S_DIV;
            end
            S_DIV: begin
                n_div_rem = w_cs_ge ? w_cs_diff : w_cs_x;
                n_quot    = {r_quot[DIV_STEPS-2:0], w_cs_ge};
                n_cnt     = r_cnt + 1'b1;
                if (r_cnt == CNT_W'(DIV_STEPS-1)) begin
                    n_state = S_COS;
                end
            end
            S_COS: begin
                n_res_val = r_neg ? (ONE_Q15 + DATA_W'(w_qc)) : (ONE_Q15 - DATA_W'(w_qc));
                n_res_deg = 1'b0;
                n_state   = S_EMIT;
            end
            S_EMIT: begin
                if (!r_out_valid || m_axis_tready) begin
                    n_out_valid = 1'b1;
                    n_out_data  = r_res_val;
                    n_out_deg   = r_res_deg;
                    n_primary   = '0;
                    n_norm_a    = '0;
                    n_norm_b    = '0;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_mode      <= MODE_DOT;
            r_primary   <= '0;
            r_norm_a    <= '0;
            r_norm_b    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_mode      <= n_mode;
            r_primary   <= n_primary;
            r_norm_a    <= n_norm_a;
            r_norm_b    <= n_norm_b;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_a         <= n_a;
        r_b         <= n_b;
        r_last      <= n_last;
        r_prod      <= n_prod;
        r_sq_n      <= n_sq_n;
        r_sq_rem    <= n_sq_rem;
        r_sq_root   <= n_sq_root;
        r_sq_second <= n_sq_second;
        r_ra        <= n_ra;
        r_cnt       <= n_cnt;
        r_den       <= n_den;
        r_div_rem   <= n_div_rem;
        r_quot      <= n_quot;
        r_neg       <= n_neg;
        r_sat       <= n_sat;
        r_res_val   <= n_res_val;
        r_res_deg   <= n_res_deg;
        r_out_data  <= n_out_data;
        r_out_deg   <= n_out_deg;
    end

    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;
    assign m_axis_tuser  = r_out_deg;

endmodule

@@ bench/testbench.sv @@
module testbench;
    import vde_pkg::*;

    localparam int          CYCLE_LIMIT   = 2_000_000;
    localparam int          PAUSE_CYCLES  = 120;
    localparam int          HOLD_CYCLES   = 400;
    localparam int          RANDOM_ITEMS  = 400;
    localparam int          EUCL_LONG_LEN = 40;
    localparam int          COS_LONG_LEN  = 24;
    localparam int          ROOT_SHIFT    = 20;
    localparam logic signed [63:0] COS_UNIT = 64'sd32768;

    typedef struct packed {
        logic [DATA_W-1:0] value;
        logic              degen;
    } t_distance_result;

    typedef enum logic [1:0] {RX_STREAM, RX_PATTERN, RX_LIGHT, RX_HEAVY} t_rx_style;

    typedef enum logic [2:0] {
        VEC_RANDOM, VEC_EXTREME, VEC_SMALL, VEC_ZERO_A, VEC_ZERO_B, VEC_EQUAL, VEC_NEGATED
    } t_vec_style;

    logic                    i_clk = 1'b0;
    logic                    i_rst_n = 1'b0;
    logic                    i_cfg_wr_en = 1'b0;
    logic [MODE_W-1:0]       i_cfg_wr_data = MODE_DOT;
    logic                    s_axis_tvalid = 1'b0;
    logic                    s_axis_tready;
    logic [2*ELEM_W-1:0]     s_axis_tdata = '0;   // elem_a, elem_b
    logic                    s_axis_tlast = 1'b0;
    logic                    m_axis_tvalid;
    logic                    m_axis_tready = 1'b0;
    logic [DATA_W-1:0]       m_axis_tdata;        // distance_value
    logic                    m_axis_tuser;        // degenerate

    logic [MODE_W-1:0]       model_mode = MODE_DOT;
    logic [DATA_W-1:0]       sum_primary = '0;
    logic [NORM_W-1:0]       sum_norm_a = '0;
    logic [NORM_W-1:0]       sum_norm_b = '0;
    t_distance_result        pending_results[$];

    int unsigned             mismatch_count = 0;
    int unsigned             cycle_count = 0;
    bit                      sender_bursty = 1'b0;
    int unsigned             burst_left = 0;

    int unsigned             hold_asked = 0;
    int unsigned             hold_served;
    int unsigned             hold_left;
    t_rx_style               rx_style;
    int unsigned             rx_style_left;
    logic [7:0]              rx_pattern;
    logic [7:0]              rx_tick;

    vector_distance_engine_core i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("** vector_distance_engine_core: FAILED **");
            $finish;
        end
    end

    function automatic logic [63:0] floor_sqrt(input logic [63:0] n);
        logic [63:0] root;
        logic [63:0] probe;
        root = '0;
        for (int i = 31; i >= 0; i--) begin
            probe = root | (64'd1 << i);
            if (probe * probe <= n) begin
                root = probe;
            end
        end
        return root;
    endfunction

    function automatic void accumulate_pair(input logic signed [ELEM_W-1:0] a,
                                            input logic signed [ELEM_W-1:0] b,
                                            input logic last);
        logic signed [63:0] wa, wb, wd, term, sq_a, sq_b, dot, sim;
        logic [63:0]        root_a, root_b, denom;
        t_distance_result   res;
        wa = a;
        wb = b;
        wd = wa - wb;
        case (model_mode)
            MODE_EUCL: term = wd * wd;
            MODE_MANH: term = (wd < 0) ? -wd : wd;
            default:   term = wa * wb;
        endcase
        sq_a = wa * wa;
        sq_b = wb * wb;
        sum_primary = sum_primary + term[DATA_W-1:0];
        sum_norm_a = sum_norm_a + sq_a[NORM_W-1:0];
        sum_norm_b = sum_norm_b + sq_b[NORM_W-1:0];
        if (!last) begin
            return;
        end
        res.degen = 1'b0;
        case (model_mode)
            MODE_DOT:  res.value = sum_primary;
            MODE_MANH: res.value = sum_primary;
            MODE_EUCL: begin
                root_a = floor_sqrt({{(64-DATA_W){1'b0}}, sum_primary});
                res.value = root_a[DATA_W-1:0];
            end
            default: begin
                if (sum_norm_a == '0 || sum_norm_b == '0) begin
                    res.value = COS_UNIT[DATA_W-1:0];
                    res.degen = 1'b1;
                end else begin
                    root_a = floor_sqrt({{(64-NORM_W){1'b0}}, sum_norm_a} << ROOT_SHIFT);
                    root_b = floor_sqrt({{(64-NORM_W){1'b0}}, sum_norm_b} << ROOT_SHIFT);
                    denom = (root_a * root_b) >> ROOT_SHIFT;
                    if (denom == '0) begin
                        denom = 64'd1;
                    end
                    dot = $signed(sum_primary);
                    sim = (dot * COS_UNIT) / $signed(denom);
                    if (sim > COS_UNIT) begin
                        sim = COS_UNIT;
                    end
                    if (sim < -COS_UNIT) begin
                        sim = -COS_UNIT;
                    end
                    sim = COS_UNIT - sim;
                    res.value = sim[DATA_W-1:0];
                end
            end
        endcase
        pending_results.insert(pending_results.size(), res);
        sum_primary = '0;
        sum_norm_a = '0;
        sum_norm_b = '0;
    endfunction

    task automatic send_pair(input int a, input int b, input bit last);
        logic signed [ELEM_W-1:0] ea, eb;
        ea = ELEM_W'(a);
        eb = ELEM_W'(b);
        s_axis_tdata <= {eb, ea};
        s_axis_tlast <= last;
        s_axis_tvalid <= 1'b1;
        do @(posedge i_clk); while (!s_axis_tready);
        accumulate_pair(ea, eb, last);
        if (sender_bursty) begin
            if (burst_left > 0) begin
                burst_left--;
            end else begin
                s_axis_tvalid <= 1'b0;
                repeat ($urandom_range(1, 6)) @(posedge i_clk);
                burst_left = $urandom_range(0, 15);
            end
        end
    endtask

    task automatic stream_stop();
        s_axis_tvalid <= 1'b0;
    endtask

    task automatic wait_for_results();
        do @(posedge i_clk); while (pending_results.size() != 0);
    endtask

    task automatic write_mode(input logic [MODE_W-1:0] mode);
        stream_stop();
        wait_for_results();
        repeat (PAUSE_CYCLES) @(posedge i_clk);
        i_cfg_wr_data <= mode;
        i_cfg_wr_en <= 1'b1;
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
        model_mode = mode;
    endtask

    function automatic int random_elem();
        return int'($urandom_range(0, 65535)) - 32768;
    endfunction

    function automatic int extreme_elem();
        case ($urandom_range(0, 4))
            0:       return -32768;
            1:       return -1;
            2:       return 0;
            3:       return 1;
            default: return 32767;
        endcase
    endfunction

    task automatic send_random_vector(input int unsigned len, input t_vec_style style);
        int a, b;
        for (int k = 0; k < len; k++) begin
            a = random_elem();
            b = random_elem();
            case (style)
                VEC_EXTREME: begin
                    a = extreme_elem();
                    b = extreme_elem();
                end
                VEC_SMALL: begin
                    a = int'($urandom_range(0, 64)) - 32;
                    b = int'($urandom_range(0, 64)) - 32;
                end
                VEC_ZERO_A:  a = 0;
                VEC_ZERO_B:  b = 0;
                VEC_EQUAL:   b = a;
                VEC_NEGATED: b = -a;
                default: ;
            endcase
            send_pair(a, b, k == len - 1);
        end
    endtask

    // The hold-off is counted here; a test raises hold_asked to request one.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
            hold_served <= 0;
            hold_left <= 0;
            rx_style <= RX_STREAM;
            rx_style_left <= 0;
            rx_pattern <= 8'hFF;
            rx_tick <= '0;
        end else begin
            rx_tick <= rx_tick + 1;
            if (hold_served != hold_asked) begin
                hold_served <= hold_asked;
                hold_left <= HOLD_CYCLES;
                m_axis_tready <= 1'b0;
            end else if (hold_left != 0) begin
                hold_left <= hold_left - 1;
                m_axis_tready <= 1'b0;
            end else begin
                if (rx_style_left == 0) begin
                    rx_style <= t_rx_style'($urandom_range(0, 3));
                    rx_style_left <= $urandom_range(16, 128);
                    rx_pattern <= 8'($urandom) | 8'h01;
                end else begin
                    rx_style_left <= rx_style_left - 1;
                end
                case (rx_style)
                    RX_STREAM:  m_axis_tready <= 1'b1;
                    RX_PATTERN: m_axis_tready <= rx_pattern[rx_tick[2:0]];
                    RX_LIGHT:   m_axis_tready <= ($urandom_range(0, 3) != 0);
                    default:    m_axis_tready <= ($urandom_range(0, 4) == 0);
                endcase
            end
        end
    end

    always @(posedge i_clk) begin : result_check
        t_distance_result want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (pending_results.size() == 0) begin
                mismatch_count++;
                $display("%0t: unexpected result, expected none, actual value %h degenerate %b",
                         $time, m_axis_tdata, m_axis_tuser);
            end else begin
                want = pending_results.pop_front();
                if (m_axis_tdata !== want.value) begin
                    mismatch_count++;
                    $display("%0t: distance_value expected %h actual %h",
                             $time, want.value, m_axis_tdata);
                end
                if (m_axis_tuser !== want.degen) begin
                    mismatch_count++;
                    $display("%0t: degenerate expected %b actual %b",
                             $time, want.degen, m_axis_tuser);
                end
            end
        end
    end

    task automatic test_reset_mode_dot();
        send_pair(-32768, -32768, 1'b1);
        send_pair(32767, -32768, 1'b0);
        send_pair(-32768, 32767, 1'b1);
        send_pair(0, 0, 1'b1);
        send_pair(12345, -321, 1'b1);
    endtask

    task automatic test_mode_extremes();
        write_mode(MODE_EUCL);
        send_pair(32767, -32768, 1'b1);
        send_pair(-32768, 32767, 1'b0);
        send_pair(100, -100, 1'b1);
        write_mode(MODE_MANH);
        send_pair(32767, -32768, 1'b1);
        send_pair(-32768, -32768, 1'b0);
        send_pair(-5, 7, 1'b1);
        write_mode(MODE_DOT);
        send_pair(32767, 32767, 1'b1);
    endtask

    task automatic test_cosine_cases();
        write_mode(MODE_COS);
        send_pair(0, 100, 1'b0);
        send_pair(0, -5, 1'b1);
        send_pair(7, 0, 1'b1);
        send_pair(0, 0, 1'b1);
        send_pair(1, 1, 1'b0);
        send_pair(1, 1, 1'b1);
        send_pair(-32768, 32767, 1'b1);
        send_pair(1, 0, 1'b0);
        send_pair(0, 1, 1'b1);
    endtask

    task automatic test_mode_switch_midvector();
        write_mode(MODE_DOT);
        send_pair(1000, 2000, 1'b0);
        send_pair(-3000, 4000, 1'b0);
        write_mode(MODE_MANH);
        send_pair(100, -100, 1'b0);
        write_mode(MODE_EUCL);
        send_pair(300, 0, 1'b1);
    endtask

    task automatic test_random_vectors();
        int unsigned sent, phase_goal, len;
        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            write_mode(MODE_W'($urandom_range(0, 3)));
            sender_bursty = ($urandom_range(0, 3) != 0);
            phase_goal = sent + $urandom_range(30, 80);
            while (sent < phase_goal) begin
                len = ($urandom_range(0, 4) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 8);
                send_random_vector(len, t_vec_style'($urandom_range(0, 6)));
                sent += len;
            end
        end
    endtask

    task automatic test_output_backpressure();
        write_mode(MODE_COS);
        sender_bursty = 1'b0;
        hold_asked <= hold_asked + 1;
        for (int v = 0; v < 24; v++) begin
            send_random_vector($urandom_range(1, 3), t_vec_style'($urandom_range(0, 6)));
        end
        stream_stop();
        wait_for_results();
    endtask

    task automatic test_long_vectors();
        sender_bursty = 1'b0;
        write_mode(MODE_EUCL);
        for (int k = 0; k < EUCL_LONG_LEN; k++) begin
            send_pair(32767, -32768, k == EUCL_LONG_LEN - 1);
        end
        write_mode(MODE_COS);
        for (int k = 0; k < COS_LONG_LEN; k++) begin
            send_pair(-32768, 12345, k == COS_LONG_LEN - 1);
        end
    endtask

    initial begin
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_reset_mode_dot();
        test_mode_extremes();
        test_cosine_cases();
        test_mode_switch_midvector();
        test_random_vectors();
        test_output_backpressure();
        test_long_vectors();
        stream_stop();
        wait_for_results();
        repeat (PAUSE_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("** vector_distance_engine_core: PASSED **");
        end else begin
            $display("** vector_distance_engine_core: FAILED **");
        end
        $finish;
    end

endmodule

@@ vector_distance_engine_core.f @@
sv/vde_pkg.sv
sv/vector_distance_engine_core.sv
bench/testbench.sv
